FILE: hw/rtl/cts_pkg.sv
// Package with types, codes and constants shared by the capture timestamp shifter.
package cts_pkg;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECHDR  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [1:0] REG_GLOBAL  = 2'd0;
  localparam logic [1:0] REG_SECONDS = 2'd1;
  localparam logic [1:0] REG_RECHDR  = 2'd2;
  localparam logic [1:0] REG_PAYLOAD = 2'd3;

  localparam logic [4:0] GLOBAL_LEN = 5'd24;
  localparam logic [4:0] RECHDR_LEN = 5'd16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] region;
  } result_t;

endpackage

FILE: hw/rtl/cts_parser.sv
// Record parser: holds the offset register, walks the headers and rewrites the seconds word.
module cts_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic signed [31:0]   cfg_time_offset,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_file,
  output cts_pkg::result_t     result
);
  import cts_pkg::*;

  logic [31:0] time_offset_r;
  phase_t      phase_r, phase_nxt;
  logic [4:0]  hbc_r, hbc_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        carry_r, carry_nxt;

  phase_t      ph;
  logic [4:0]  hbc;
  logic        carry;
  logic [3:0]  k;
  logic [4:0]  cnt;
  logic [7:0]  ofs;
  logic [8:0]  sum;
  logic [31:0] rem_dec;

  always_comb begin
    ph        = start_of_file ? PH_GLOBAL : phase_r;
    hbc       = start_of_file ? 5'd0 : hbc_r;
    carry     = start_of_file ? 1'b0 : carry_r;
    k         = hbc[3:0];
    cnt       = 5'd0;
    ofs       = 8'(time_offset_r >> {k[1:0], 3'b000});
    sum       = {1'b0, data_byte} + {1'b0, ofs} + 9'((k == 4'd0) ? 1'b0 : carry);
    rem_dec   = rem_r - 32'd1;
    phase_nxt = ph;
    hbc_nxt   = hbc;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    carry_nxt = carry;
    result.out_byte = data_byte;
    result.region   = REG_RECHDR;
    case (ph)
      PH_GLOBAL: begin
        result.region = REG_GLOBAL;
        cnt = hbc + 5'd1;
        hbc_nxt = cnt;
        if (cnt >= GLOBAL_LEN) begin
          phase_nxt = PH_RECHDR;
          hbc_nxt   = 5'd0;
          carry_nxt = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        result.region = REG_PAYLOAD;
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = PH_RECHDR;
          hbc_nxt   = 5'd0;
          carry_nxt = 1'b0;
        end
      end
      default: begin
        if (k[3:2] == 2'b00) begin
          result.out_byte = sum[7:0];
          result.region   = REG_SECONDS;
          carry_nxt       = sum[8];
        end else begin
          result.region = REG_RECHDR;
          if (k[3:2] == 2'b10) begin
            case (k[1:0])
              2'd0:    len_nxt[7:0]   = data_byte;
              2'd1:    len_nxt[15:8]  = data_byte;
              2'd2:    len_nxt[23:16] = data_byte;
              default: len_nxt[31:24] = data_byte;
            endcase
          end
        end
        cnt = {1'b0, k} + 5'd1;
        hbc_nxt   = cnt;
        phase_nxt = PH_RECHDR;
        if (cnt >= RECHDR_LEN) begin
          hbc_nxt   = 5'd0;
          carry_nxt = 1'b0;
          if (len_nxt != 32'd0) begin
            rem_nxt   = len_nxt;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_offset_r <= 32'd0;
      phase_r       <= PH_GLOBAL;
      hbc_r         <= 5'd0;
      len_r         <= 32'd0;
      rem_r         <= 32'd0;
      carry_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_offset_r <= cfg_time_offset;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        hbc_r   <= hbc_nxt;
        len_r   <= len_nxt;
        rem_r   <= rem_nxt;
        carry_r <= carry_nxt;
      end
    end
  end

  a_sof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && start_of_file |=> phase_r == PH_GLOBAL && hbc_r == 5'd1)
    else $error("start flag did not restart global header");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != 32'd0)
    else $error("payload phase with no bytes remaining");

  a_global_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_GLOBAL |-> hbc_r < GLOBAL_LEN)
    else $error("global header count out of range");

  a_rechdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RECHDR |-> hbc_r < RECHDR_LEN)
    else $error("record header count out of range");

endmodule

FILE: hw/rtl/cts_out_reg.sv
// Output register that holds one result item while the receiver stalls.
module cts_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cts_pkg::result_t din,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output cts_pkg::result_t dout
);
  import cts_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign dout      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

FILE: hw/rtl/capture_timestamp_shifter_top.sv
// Top level of the capture timestamp shifter.
// Takes a little-endian packet-capture stream one byte per item on the
// in_ channel and returns one item per byte on the out_ channel: the byte
// (seconds-word bytes of each record header rewritten by adding the signed
// cfg offset modulo 2^32) and a region tag (0 global header, 1 seconds,
// 2 other record header, 3 payload). in_start_of_file marks byte 0 of a
// new file and restarts parsing there.
// out_valid rises in the cycle after an input is accepted.
// Throughput: one item per cycle while out_ready is high; the parser state
// updates in the accept cycle and the result lands in one output register.
// When the receiver stalls, the output register holds its item and in_ready
// drops until it is taken; in_ready is high again in the cycle out_ready is.
// The cfg channel is always ready; the offset is registered when cfg_valid is high.
// Reset (synchronous, rst_n low) clears the offset to zero, returns the
// parser to the global header and empties the output register.
module capture_timestamp_shifter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_time_offset,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_region
);
  import cts_pkg::*;

  logic    accept;
  result_t res;
  result_t res_q;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  cts_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_time_offset (cfg_time_offset),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .start_of_file   (in_start_of_file),
    .result          (res)
  );

  cts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .din       (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign out_byte   = res_q.out_byte;
  assign out_region = res_q.region;

endmodule

FILE: test/capture_timestamp_shifter_top_tb.sv
// Testbench for capture_timestamp_shifter_top: capture streams checked against a local predictor.
module capture_timestamp_shifter_top_tb;
  import cts_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       sof;
  } byte_item_t;

  localparam int HOLD_AT   = 900;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [31:0] cfg_time_offset = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = '0;
  logic in_start_of_file = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_region;

  byte_item_t feed_q[$];
  result_t    rewritten_q[$];

  phase_t      parse_ph = PH_GLOBAL;
  logic [4:0]  hdr_cnt = '0;
  logic [31:0] rec_len = '0;
  logic [31:0] pay_left = '0;
  logic        sec_carry = 1'b0;
  logic [31:0] time_ofs = '0;

  int in_gap_max = 0;
  int out_stall_max = 0;
  int gap_left = 0;
  int stall_left = 0;
  int got_cnt = 0;
  bit failed = 1'b0;

  capture_timestamp_shifter_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_time_offset (cfg_time_offset),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_start_of_file(in_start_of_file),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_region      (out_region)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t rewrite_byte(logic [7:0] b, logic sof);
    result_t    r;
    logic [3:0] k;
    logic [8:0] sum;
    r.out_byte = b;
    if (sof) begin
      parse_ph = PH_GLOBAL;
      hdr_cnt = '0;
      sec_carry = 1'b0;
    end
    case (parse_ph)
      PH_GLOBAL: begin
        r.region = REG_GLOBAL;
        hdr_cnt = hdr_cnt + 5'd1;
        if (hdr_cnt >= GLOBAL_LEN) begin
          parse_ph = PH_RECHDR;
          hdr_cnt = '0;
          sec_carry = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        r.region = REG_PAYLOAD;
        pay_left = pay_left - 32'd1;
        if (pay_left == 32'd0) begin
          parse_ph = PH_RECHDR;
          hdr_cnt = '0;
          sec_carry = 1'b0;
        end
      end
      default: begin
        k = hdr_cnt[3:0];
        if (k < 4'd4) begin
          sum = {1'b0, b} + {1'b0, time_ofs[8*k +: 8]} + {8'd0, (k != 4'd0) & sec_carry};
          r.out_byte = sum[7:0];
          sec_carry = sum[8];
          r.region = REG_SECONDS;
        end else begin
          r.region = REG_RECHDR;
          if (k >= 4'd8 && k < 4'd12) rec_len[8*(k-8) +: 8] = b;
        end
        hdr_cnt = 5'(k) + 5'd1;
        parse_ph = PH_RECHDR;
        if (hdr_cnt >= RECHDR_LEN) begin
          hdr_cnt = '0;
          sec_carry = 1'b0;
          if (rec_len != 32'd0) begin
            pay_left = rec_len;
            parse_ph = PH_PAYLOAD;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int draw_wait(int max_w);
    if (max_w == 0 || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, max_w);
  endfunction

  function automatic void put_byte(logic [7:0] b, logic sof);
    byte_item_t it;
    it.data = b;
    it.sof = sof;
    feed_q.push_back(it);
  endfunction

  function automatic void put_file_head();
    put_byte(8'($urandom), 1'b1);
    repeat (23) put_byte(8'($urandom), 1'b0);
  endfunction

  function automatic void put_record(logic [31:0] secs, logic [31:0] len, int hdr_n, int pay_n);
    logic [7:0] b;
    for (int i = 0; i < hdr_n; i++) begin
      if (i < 4) b = secs[8*i +: 8];
      else if (i >= 8 && i < 12) b = len[8*(i-8) +: 8];
      else b = 8'($urandom);
      put_byte(b, 1'b0);
    end
    for (int i = 0; i < pay_n; i++) put_byte(8'($urandom), 1'b0);
  endfunction

  function automatic void put_random_file();
    int n_rec;
    int pick;
    int n_noise;
    logic [31:0] secs;
    logic [31:0] len;
    put_file_head();
    n_rec = $urandom_range(1, 5);
    for (int r = 0; r < n_rec; r++) begin
      pick = $urandom_range(0, 5);
      secs = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
             (pick == 2) ? {24'hFF_FFFF, 8'($urandom)} : $urandom;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        put_record(secs, 32'd0, 16, 0);
      end else if (pick == 3) begin
        put_record(secs, {8'($urandom_range(1, 255)), 24'($urandom)}, 16, $urandom_range(0, 8));
        return;
      end else if (pick == 4) begin
        put_record(secs, $urandom_range(1, 20), $urandom_range(1, 15), 0);
        return;
      end else begin
        len = $urandom_range(1, 20);
        put_record(secs, len, 16, (pick == 5) ? $urandom_range(0, len - 1) : len);
        if (pick == 5) return;
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      n_noise = $urandom_range(1, 4);
      repeat (n_noise) put_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (feed_q.size() != 0 || in_valid || rewritten_q.size() != 0);
  endtask

  task automatic write_offset(logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_time_offset <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    time_ofs = v;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive
    byte_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        rewritten_q.push_back(rewrite_byte(in_data_byte, in_start_of_file));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          nxt = feed_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_start_of_file <= nxt.sof;
          gap_left <= draw_wait(in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    result_t want;
    int wait_n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      got_cnt <= got_cnt + 1;
      if (rewritten_q.size() == 0) begin
        $display("%0t: unexpected item, byte %h region %0d", $time, out_byte, out_region);
        failed = 1'b1;
      end else begin
        want = rewritten_q.pop_front();
        if (out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, out_byte);
          failed = 1'b1;
        end
        if (out_region !== want.region) begin
          $display("%0t: out_region expected %0d actual %0d", $time, want.region, out_region);
          failed = 1'b1;
        end
      end
      wait_n = draw_wait(out_stall_max);
      if (got_cnt == HOLD_AT) wait_n = LONG_HOLD;
      stall_left <= wait_n;
      out_ready <= (wait_n == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic [31:0] next_ofs;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        case (p)
          1: next_ofs = 32'h0000_0001;
          2: next_ofs = 32'hFFFF_FFFF;
          3: next_ofs = 32'h7FFF_FFFF;
          4: next_ofs = 32'h8000_0000;
          7: next_ofs = 32'h0000_0000;
          default: next_ofs = $urandom;
        endcase
        write_offset(next_ofs);
      end
      in_gap_max = (p % 2 == 1) ? 18 : 0;
      out_stall_max = (p % 4 >= 2) ? 18 : 0;
      if (p == 0) begin
        put_file_head();
        put_record(32'hFFFF_FFFF, 32'd0, 16, 0);
        put_record(32'h0000_00FF, 32'd1, 16, 1);
        put_record(32'h8000_0000, 32'hFFFF_FFFF, 16, 2);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_file_head();
        put_record(32'h0000_0000, 32'd5, 6, 0);
      end
      while (feed_q.size() < 210) put_random_file();
      drain();
    end
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("capture_timestamp_shifter_top_tb passed");
    end else begin
      $display("capture_timestamp_shifter_top_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("capture_timestamp_shifter_top_tb failed");
    $finish;
  end

endmodule
